[hdl/kwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwd_pkg
// Shared constants, register map, keys and control and status structs for the keyed
// watchdog with software reset lines.
// ----------------------------------------------------------------------------
package kwd_pkg;

  // Sizing
  localparam int unsigned TicksPerUnit   = 512;
  localparam int unsigned LineCount      = 24;
  localparam int unsigned LengthBits     = 11;
  localparam int unsigned PrescaleBits   = $clog2(TicksPerUnit);
  localparam int unsigned ModeBits       = 9;
  localparam int unsigned LineOutBits    = 24;

  // Request kinds
  localparam logic [1:0] ReqRead  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  // Register map (byte offsets)
  localparam logic [7:0] OfsMode    = 8'h00;
  localparam logic [7:0] OfsLength  = 8'h04;
  localparam logic [7:0] OfsRestart = 8'h08;
  localparam logic [7:0] OfsSwRst   = 8'h14;
  localparam logic [7:0] OfsLines   = 8'h18;
  localparam logic [7:0] OfsLineEn  = 8'hfc;

  // Keys
  localparam logic [7:0]  KeyMode    = 8'h22;
  localparam logic [4:0]  KeyLength  = 5'h08;
  localparam logic [31:0] KeyRestart = 32'h0000_1971;
  localparam logic [31:0] KeySwRst   = 32'h0000_1209;
  localparam logic [7:0]  KeyLines   = 8'h88;

  // Mode bit positions
  localparam int unsigned ModeEn    = 0;
  localparam int unsigned ModePol   = 1;
  localparam int unsigned ModeExRst = 2;
  localparam int unsigned ModeIrq   = 3;
  localparam int unsigned ModeDual  = 6;
  localparam int unsigned ModeCsel  = 8;

  // Register block to timer
  typedef struct packed {
    logic                  tick;
    logic                  restart;
    logic                  enable;
    logic                  dual;
    logic                  irq_en;
    logic [LengthBits-1:0] length;
  } timer_ctrl_t;

  // Timer back to top level
  typedef struct packed {
    logic irq;
    logic expire;
  } timer_stat_t;

endpackage

[hdl/kwd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwd_req_if / kwd_rsp_if
// Valid/ready channels for watchdog requests and per-request results.
// ----------------------------------------------------------------------------
interface kwd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  address;
  logic [31:0] write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

interface kwd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        interrupt_out;
  logic        system_reset;
  logic        external_reset_pin;
  logic [23:0] reset_line_bits;
  logic        count_select_out;

  modport source (output valid, read_data, interrupt_out, system_reset,
                  external_reset_pin, reset_line_bits, count_select_out,
                  input ready);
  modport sink   (input valid, read_data, interrupt_out, system_reset,
                  external_reset_pin, reset_line_bits, count_select_out,
                  output ready);
endinterface

[hdl/kwd_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwd_regs
// Keyed register file: write decode with key checks (none on the line-enable
// register), read mux, and the control strobes handed to the timer.
// ----------------------------------------------------------------------------
module kwd_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic [1:0]                            req_type_i,
  input  logic [7:0]                            address_i,
  input  logic [31:0]                           write_data_i,
  output kwd_pkg::timer_ctrl_t                  ctrl_o,
  output logic                                  sw_reset_o,
  output logic [31:0]                           read_data_o,
  output logic [kwd_pkg::ModeBits-1:0]          mode_next_o,
  output logic [kwd_pkg::LineCount-1:0]         lines_next_o
);

  logic [kwd_pkg::ModeBits-1:0]   mode_q, mode_d;
  logic [kwd_pkg::LengthBits-1:0] length_q, length_d;
  logic [kwd_pkg::LineCount-1:0]  lines_q, lines_d;
  logic [kwd_pkg::LineCount-1:0]  line_en_q, line_en_d;
  logic                           wr, rd, restart, swrst;

  assign wr = fire_i && (req_type_i == kwd_pkg::ReqWrite);
  assign rd = req_type_i == kwd_pkg::ReqRead;

  // Decode writes and their key checks
  always_comb begin
    mode_d   = mode_q;
    length_d = length_q;
    lines_d  = lines_q;
    line_en_d = line_en_q;
    restart  = 1'b0;
    swrst    = 1'b0;
    if (wr) begin
      case (address_i)
        kwd_pkg::OfsMode: begin
          if (write_data_i[31:24] == kwd_pkg::KeyMode) begin
            mode_d = write_data_i[kwd_pkg::ModeBits-1:0];
          end
        end
        kwd_pkg::OfsLength: begin
          if (write_data_i[4:0] == kwd_pkg::KeyLength) begin
            length_d = write_data_i[5 +: kwd_pkg::LengthBits];
          end
        end
        kwd_pkg::OfsRestart: begin
          restart = write_data_i == kwd_pkg::KeyRestart;
        end
        kwd_pkg::OfsSwRst: begin
          swrst = write_data_i == kwd_pkg::KeySwRst;
        end
        kwd_pkg::OfsLines: begin
          if (write_data_i[31:24] == kwd_pkg::KeyLines) begin
            lines_d = write_data_i[kwd_pkg::LineCount-1:0];
          end
        end
        kwd_pkg::OfsLineEn: begin
          line_en_d = write_data_i[kwd_pkg::LineCount-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    read_data_o = '0;
    if (rd) begin
      case (address_i)
        kwd_pkg::OfsMode:   read_data_o = 32'(mode_q);
        kwd_pkg::OfsLength: read_data_o = 32'(length_q) << 5;
        kwd_pkg::OfsLines:  read_data_o = 32'(lines_q);
        kwd_pkg::OfsLineEn: read_data_o = 32'(line_en_q);
        default:            read_data_o = '0;
      endcase
    end
  end

  // Hold register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      length_q  <= '1;
      lines_q   <= '0;
      line_en_q <= '0;
    end else begin
      mode_q    <= mode_d;
      length_q  <= length_d;
      lines_q   <= lines_d;
      line_en_q <= line_en_d;
    end
  end

  // Timer controls use the mode in force before this transfer
  assign ctrl_o.tick    = fire_i && (req_type_i == kwd_pkg::ReqTick);
  assign ctrl_o.restart = restart;
  assign ctrl_o.enable  = mode_q[kwd_pkg::ModeEn];
  assign ctrl_o.dual    = mode_q[kwd_pkg::ModeDual];
  assign ctrl_o.irq_en  = mode_q[kwd_pkg::ModeIrq];
  assign ctrl_o.length  = length_q;

  assign sw_reset_o   = swrst;
  assign mode_next_o  = mode_d;
  assign lines_next_o = lines_d;

endmodule

[hdl/kwd_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwd_timer
// Tick prescaler and unit countdown, two-stage in dual mode, with pre-timeout interrupt.
// ----------------------------------------------------------------------------
module kwd_timer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kwd_pkg::timer_ctrl_t ctrl_i,
  output kwd_pkg::timer_stat_t stat_o
);

  localparam logic [kwd_pkg::PrescaleBits-1:0] PreLast =
    kwd_pkg::PrescaleBits'(kwd_pkg::TicksPerUnit - 1);
  localparam logic [kwd_pkg::LengthBits-1:0] UnitOne =
    kwd_pkg::LengthBits'(1);

  logic [kwd_pkg::PrescaleBits-1:0] pre_q, pre_d;
  logic [kwd_pkg::LengthBits-1:0]   units_q, units_d;
  logic                             stage_q, stage_d;
  logic                             irq_q, irq_d;
  logic                             expire;

  // Advance prescaler and unit counter
  always_comb begin
    pre_d   = pre_q;
    units_d = units_q;
    stage_d = stage_q;
    irq_d   = irq_q;
    expire  = 1'b0;
    if (ctrl_i.restart) begin
      units_d = ctrl_i.length;
      pre_d   = '0;
      stage_d = 1'b0;
      irq_d   = 1'b0;
    end else if (ctrl_i.tick && ctrl_i.enable) begin
      if (pre_q != PreLast) begin
        pre_d = pre_q + 1'b1;
      end else begin
        pre_d = '0;
        if (units_q > UnitOne) begin
          units_d = units_q - 1'b1;
        end else if (ctrl_i.dual && !stage_q) begin
          // First expiry in dual mode: reload and flag
          units_d = ctrl_i.length;
          stage_d = 1'b1;
          if (ctrl_i.irq_en) begin
            irq_d = 1'b1;
          end
        end else begin
          // Final expiry: reload and fire reset
          units_d = ctrl_i.length;
          stage_d = 1'b0;
          irq_d   = 1'b0;
          expire  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q   <= '0;
      units_q <= '1;
      stage_q <= 1'b0;
      irq_q   <= 1'b0;
    end else begin
      pre_q   <= pre_d;
      units_q <= units_d;
      stage_q <= stage_d;
      irq_q   <= irq_d;
    end
  end

  assign stat_o.irq    = irq_d;
  assign stat_o.expire = expire;

endmodule

[hdl/keyed_watchdog_with_reset_lines.sv]
`timescale 1ns / 1ps
// The result is registered and valid in the cycle after the request transfer.
// Throughput: one request per cycle; a request is taken whenever the result
// register is empty or its result is being taken in the same cycle.
// Reset: asynchronous, active low; watchdog disabled, longest length loaded,
// no reset line asserted, result register empty.
// ----------------------------------------------------------------------------
// keyed_watchdog_with_reset_lines
// Top level: register file, timer and result register.
// ----------------------------------------------------------------------------
module keyed_watchdog_with_reset_lines (
  input  logic           clk_i,
  input  logic           rst_ni,
  kwd_req_if.sink        req,
  kwd_rsp_if.source      rsp
);

  kwd_pkg::timer_ctrl_t                ctrl;
  kwd_pkg::timer_stat_t                stat;
  logic                                fire;
  logic                                sw_reset;
  logic                                pulse;
  logic [31:0]                         read_data;
  logic [kwd_pkg::ModeBits-1:0]        mode_next;
  logic [kwd_pkg::LineCount-1:0]       lines_next;

  logic                                vld_q;
  logic [31:0]                         rdata_q;
  logic                                irq_q, sysrst_q, pin_q, csel_q;
  logic [kwd_pkg::LineOutBits-1:0]     lines_q;
  logic                                pin_d;

  // Take a transfer whenever the result slot frees up
  assign req.ready = !vld_q || rsp.ready;
  assign fire      = req.valid && req.ready;

  kwd_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_type_i   (req.req_type),
    .address_i    (req.address),
    .write_data_i (req.write_data),
    .ctrl_o       (ctrl),
    .sw_reset_o   (sw_reset),
    .read_data_o  (read_data),
    .mode_next_o  (mode_next),
    .lines_next_o (lines_next)
  );

  kwd_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  // External pin, when enabled in the mode, follows polarity, driven active during the pulse
  assign pulse = sw_reset || stat.expire;
  assign pin_d = mode_next[kwd_pkg::ModeExRst] &&
                 (pulse ? mode_next[kwd_pkg::ModePol] : !mode_next[kwd_pkg::ModePol]);

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (req.ready) begin
      vld_q <= req.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q  <= read_data;
      irq_q    <= stat.irq;
      sysrst_q <= pulse;
      pin_q    <= pin_d;
      lines_q  <= kwd_pkg::LineOutBits'(lines_next);
      csel_q   <= mode_next[kwd_pkg::ModeCsel];
    end
  end

  assign rsp.valid              = vld_q;
  assign rsp.read_data          = rdata_q;
  assign rsp.interrupt_out      = irq_q;
  assign rsp.system_reset       = sysrst_q;
  assign rsp.external_reset_pin = pin_q;
  assign rsp.reset_line_bits    = lines_q;
  assign rsp.count_select_out   = csel_q;

endmodule
